FILE: rtl/core/bss_pkg.sv
`default_nettype none

package bss_pkg;

  // Default sizing of the search window and the offset counter
  localparam int BSS_MAX_PATTERN_BYTES = 8;
  localparam int BSS_OFFSET_BITS       = 48;

  // Fixed field widths
  localparam int BSS_PATTERN_W = 64;
  localparam int BSS_LENGTH_W  = 4;
  localparam int BSS_LIMIT_W   = 48;
  localparam int BSS_MATCH_W   = 48;
  localparam int BSS_STATUS_W  = 2;
  localparam int BSS_CFG_IDX_W = 2;

  // Result status codes
  typedef enum logic [BSS_STATUS_W-1:0] {
    ST_FOUND = 2'd0,
    ST_END   = 2'd1,
    ST_LIMIT = 2'd2
  } bss_status_t;

  // Configuration register indexes
  typedef enum logic [BSS_CFG_IDX_W-1:0] {
    REG_PATTERN_BYTES  = 2'd0,
    REG_PATTERN_LENGTH = 2'd1,
    REG_START_LIMIT    = 2'd2,
    REG_LIMIT_ENABLE   = 2'd3
  } bss_cfg_reg_t;

  // Control handed to every window cell
  typedef struct packed {
    logic shift;
    logic clear;
  } bss_cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/core/bss_window_cell.sv
`default_nettype none

module bss_window_cell
  import bss_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire bss_cell_ctrl_t ctrl,
  input  wire logic [7:0]     din,
  input  wire logic [7:0]     pat_byte,
  input  wire logic           in_use,
  output logic      [7:0]     dout,
  output logic                ok
);

  logic [7:0] byte_r;

  // One stage of the byte window; passes its byte on at every shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= '0;
    end else if (ctrl.clear) begin
      byte_r <= '0;
    end else if (ctrl.shift) begin
      byte_r <= din;
    end
  end

  assign dout = byte_r;

  // A cell outside the active signature length never blocks a match
  assign ok = !in_use || (byte_r == pat_byte);

endmodule

`default_nettype wire

FILE: rtl/core/byte_signature_search_core.sv
// Timing: a result is registered in the output register in the cycle after the input transfer that causes it.
// Throughput: one byte per cycle while in_stall is low; set by the combinational window compare across the
//   cell row together with the start-offset subtract and limit compare.
// Reset (rst_n low, synchronous): window cells and byte counter clear, output empties,
//   registers return to pattern 0, length 1, limit 0, limit disabled.
`default_nettype none

module byte_signature_search_core
  import bss_pkg::*;
#(
  parameter int MAX_PATTERN_BYTES = BSS_MAX_PATTERN_BYTES,
  parameter int OFFSET_BITS       = BSS_OFFSET_BITS
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // configuration
  input  wire logic                     cfg_we,
  input  wire logic [BSS_CFG_IDX_W-1:0] cfg_index,
  input  wire logic [BSS_PATTERN_W-1:0] cfg_wdata,
  // byte stream
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [7:0]               in_data_byte,
  input  wire logic                     in_stream_end,
  // results
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [BSS_STATUS_W-1:0]       out_status,
  output logic [BSS_MATCH_W-1:0]        out_match_offset
);

  localparam int LEN_W  = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int NCELL  = (MAX_PATTERN_BYTES > 1) ? MAX_PATTERN_BYTES - 1 : 1;
  localparam int CMP_W  = (OFFSET_BITS > BSS_LIMIT_W) ? OFFSET_BITS : BSS_LIMIT_W;

  // Configuration registers
  logic [BSS_PATTERN_W-1:0] pattern_r;
  logic [BSS_LENGTH_W-1:0]  length_r;
  logic [BSS_LIMIT_W-1:0]   limit_r;
  logic                     limit_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r  <= '0;
      length_r   <= BSS_LENGTH_W'(1);
      limit_r    <= '0;
      limit_en_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (bss_cfg_reg_t'(cfg_index))
        REG_PATTERN_BYTES:  pattern_r  <= cfg_wdata;
        REG_PATTERN_LENGTH: length_r   <= cfg_wdata[BSS_LENGTH_W-1:0];
        REG_START_LIMIT:    limit_r    <= cfg_wdata[BSS_LIMIT_W-1:0];
        REG_LIMIT_ENABLE:   limit_en_r <= cfg_wdata[0];
      endcase
    end
  end

  // Effective signature length, clamped to 1..MAX_PATTERN_BYTES
  logic [LEN_W-1:0] len_u;
  logic [LEN_W-1:0] len_m1;

  always_comb begin
    if (length_r == '0) begin
      len_u = LEN_W'(1);
    end else if (length_r > BSS_LENGTH_W'(MAX_PATTERN_BYTES)) begin
      len_u = LEN_W'(MAX_PATTERN_BYTES);
    end else begin
      len_u = LEN_W'(length_r);
    end
  end

  assign len_m1 = len_u - LEN_W'(1);

  // Handshake: accept whenever the output register is free or being emptied
  logic out_valid_r;
  logic in_xfer;

  assign in_stall = out_valid_r && out_stall;
  assign in_xfer  = in_valid && !in_stall;

  // Byte counter and candidate start offset
  logic [OFFSET_BITS-1:0] cnt_r;
  logic [OFFSET_BITS-1:0] cnt_nxt;
  logic [OFFSET_BITS-1:0] start_w;
  logic                   candidate;
  logic                   over;

  assign start_w   = cnt_r - OFFSET_BITS'(len_m1);
  assign candidate = cnt_r >= OFFSET_BITS'(len_m1);
  assign over      = candidate && limit_en_r && (CMP_W'(start_w) > CMP_W'(limit_r));

  // Window cell row
  bss_cell_ctrl_t   cell_ctrl;
  logic [7:0]       cell_q   [NCELL];
  logic [7:0]       cell_pat [NCELL];
  logic [NCELL-1:0] cell_use;
  logic [NCELL-1:0] cell_ok;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    logic [2:0] pidx;

    // cell i holds the byte i+1 places back and meets signature byte len-2-i
    assign pidx        = 3'(int'(len_u) - 2 - i);
    assign cell_pat[i] = pattern_r[{pidx, 3'b000} +: 8];
    assign cell_use[i] = (i + 1) < int'(len_u);

    bss_window_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (cell_ctrl),
      .din      ((i == 0) ? in_data_byte : cell_q[(i == 0) ? 0 : i - 1]),
      .pat_byte (cell_pat[i]),
      .in_use   (cell_use[i]),
      .dout     (cell_q[i]),
      .ok       (cell_ok[i])
    );
  end

  // Newest byte against the last signature byte
  logic [2:0] last_idx;
  logic       hit;

  assign last_idx = 3'(len_m1);
  assign hit      = candidate && !over && (&cell_ok) &&
                    (pattern_r[{last_idx, 3'b000} +: 8] == in_data_byte);

  // Per-transfer decision
  logic        result;
  logic        restart;
  bss_status_t res_status;

  always_comb begin
    result     = 1'b0;
    res_status = ST_END;
    priority if (in_stream_end) begin
      result     = 1'b1;
      res_status = ST_END;
    end else if (over) begin
      result     = 1'b1;
      res_status = ST_LIMIT;
    end else if (hit) begin
      result     = 1'b1;
      res_status = ST_FOUND;
    end else begin
      result     = 1'b0;
      res_status = ST_END;
    end
    restart         = in_xfer && result;
    cell_ctrl.clear = restart;
    cell_ctrl.shift = in_xfer && !result;
    cnt_nxt         = cnt_r;
    if (restart) begin
      cnt_nxt = '0;
    end else if (cell_ctrl.shift) begin
      cnt_nxt = cnt_r + OFFSET_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Output register
  logic [BSS_STATUS_W-1:0] status_r;
  logic [BSS_MATCH_W-1:0]  offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (restart) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (restart) begin
      status_r <= res_status;
      offset_r <= (res_status == ST_FOUND) ? BSS_MATCH_W'(start_w) : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_match_offset = offset_r;

endmodule

`default_nettype wire

FILE: rtl/core/bss_checker.sv
`default_nettype none

module bss_checker
  import bss_pkg::*;
(
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    in_valid,
  input wire logic                    in_stall,
  input wire logic                    in_stream_end,
  input wire logic                    out_valid,
  input wire logic                    out_stall,
  input wire logic [BSS_STATUS_W-1:0] out_status,
  input wire logic [BSS_MATCH_W-1:0]  out_match_offset
);

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_match_offset))
    else $error("result changed while stalled");

  // Only defined status codes appear
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_FOUND || out_status == ST_END || out_status == ST_LIMIT))
    else $error("undefined status code");

  // Offset is zero unless a match was found
  a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_FOUND |-> out_match_offset == '0)
    else $error("nonzero offset without match");

  // An end marker transfer yields an end result in the next cycle
  a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_stream_end |=> out_valid && out_status == ST_END)
    else $error("end marker gave no end result");

endmodule

bind byte_signature_search_core bss_checker u_bss_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_stream_end    (in_stream_end),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_status       (out_status),
  .out_match_offset (out_match_offset)
);

`default_nettype wire
